/* src/s8dd_pkg.sv */
// ----------------------------------------------------------------------------
// s8dd_pkg
// Shared constants, tables, types and helper functions of the simple8b
// delta-of-delta decoder.
// ----------------------------------------------------------------------------
package s8dd_pkg;

  localparam int unsigned MAX_ROWS    = 512;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned LANES       = 8;

  localparam int unsigned VW          = VALUE_WIDTH;
  localparam int unsigned OUT_W       = 64;
  localparam int unsigned OUT_LANES   = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned SEL_W       = 4;
  localparam int unsigned CFG_W       = 10;
  localparam int unsigned FIRST_ROW_W = 9;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned ROW_W       = $clog2(MAX_ROWS + 1);
  localparam int unsigned LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned PFX_LEVELS  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned RESULT_CAP  = 64;
  localparam int unsigned CAP_ROWS    = RESULT_CAP * LANES;
  localparam int unsigned RUN_CNT_W   = 28;
  localparam int unsigned RUN_VAL_W   = 36;
  localparam int unsigned SHIFT_W     = 10;

  localparam logic [CFG_W-1:0]  ROW_LIMIT_RESET = CFG_W'(512);
  localparam logic [SEL_W-1:0]  SEL_RUN  = SEL_W'(15);
  localparam logic [WORD_W-1:0] RUN_MASK = {{(WORD_W - RUN_VAL_W){1'b0}}, {RUN_VAL_W{1'b1}}};

  localparam int unsigned FIELD_BITS [16] =
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 16, 21, 32, 64, 36};
  localparam int unsigned FIELD_COUNT [16] =
    '{0, 64, 32, 21, 16, 12, 10, 9, 8, 6, 5, 4, 3, 2, 1, 0};

  typedef enum logic {
    SEQ_IDLE,
    SEQ_ISSUE
  } seq_state_e;

  typedef struct packed {
    logic                   vld;
    logic                   clr;
    logic                   last;
    logic [CNT_W-1:0]       cnt;
    logic [FIRST_ROW_W-1:0] first_row;
    logic [VW-1:0]          total;
  } grp_meta_t;

  function automatic logic [WORD_W-1:0] field_mask(input logic [SEL_W-1:0] sel);
    logic [WORD_W-1:0] m;
    m = '0;
    if (FIELD_BITS[sel] != 0) begin
      m = {WORD_W{1'b1}} >> (WORD_W - FIELD_BITS[sel]);
    end
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] group_shift(input logic [SEL_W-1:0] sel);
    logic [SHIFT_W-1:0] s;
    s = '0;
    if (sel != SEL_RUN) begin
      s = SHIFT_W'(FIELD_BITS[sel] * LANES);
    end
    return s;
  endfunction

  function automatic logic [VW-1:0] unzigzag(input logic [WORD_W-1:0] v);
    return VW'((v >> 1) ^ {WORD_W{v[0]}});
  endfunction

endpackage

/* src/s8dd_if.sv */
// ----------------------------------------------------------------------------
// s8dd_if
// Valid/ready channels of the decoder: block beats in, row group beats out.
// ----------------------------------------------------------------------------
interface s8dd_in_if;
  import s8dd_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_batch;
  logic [SEL_W-1:0]  selector;
  logic [WORD_W-1:0] block_word;

  modport source (output valid, output start_batch, output selector, output block_word,
                  input ready);
  modport sink   (input valid, input start_batch, input selector, input block_word,
                  output ready);
endinterface

interface s8dd_out_if;
  import s8dd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIRST_ROW_W-1:0] first_row;
  logic [CNT_W-1:0]       lane_count;
  logic signed [OUT_W-1:0] value_0;
  logic signed [OUT_W-1:0] value_1;
  logic signed [OUT_W-1:0] value_2;
  logic signed [OUT_W-1:0] value_3;
  logic signed [OUT_W-1:0] value_4;
  logic signed [OUT_W-1:0] value_5;
  logic signed [OUT_W-1:0] value_6;
  logic signed [OUT_W-1:0] value_7;
  logic                   block_done;

  modport source (output valid, output first_row, output lane_count,
                  output value_0, output value_1, output value_2, output value_3,
                  output value_4, output value_5, output value_6, output value_7,
                  output block_done, input ready);
  modport sink   (input valid, input first_row, input lane_count,
                  input value_0, input value_1, input value_2, input value_3,
                  input value_4, input value_5, input value_6, input value_7,
                  input block_done, output ready);
endinterface

/* src/s8dd_seq.sv */
// ----------------------------------------------------------------------------
// s8dd_seq
// Block sequencer: takes one block beat, clips it to the row limit and issues
// it as lane groups, shifting the word down one group each cycle adv_i is set.
// ----------------------------------------------------------------------------
module s8dd_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  s8dd_in_if.sink                       in_ch_i,
  input  logic                          cfg_we_i,
  input  logic [s8dd_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          adv_i,
  output s8dd_pkg::grp_meta_t           tok_o,
  output logic [s8dd_pkg::SEL_W-1:0]    sel_o,
  output logic [s8dd_pkg::WORD_W-1:0]   word_o
);
  import s8dd_pkg::*;

  seq_state_e              state_q, state_d;
  logic [CFG_W-1:0]        cfg_q;
  logic [ROW_W-1:0]        row_q;
  logic [ROW_W-1:0]        rem_q;
  logic                    clr_q;
  logic [WORD_W-1:0]       word_q;
  logic [SEL_W-1:0]        sel_q;

  logic                    accept;
  logic                    issuing;
  logic                    tok_last;
  logic [CNT_W-1:0]        tok_cnt;
  logic [ROW_W-1:0]        row_base;
  logic [ROW_W-1:0]        limit;
  logic [ROW_W-1:0]        room;
  logic [RUN_CNT_W-1:0]    count;
  logic [ROW_W-1:0]        n_room;
  logic [ROW_W-1:0]        n_take;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_ch_i.valid) state_d = SEQ_ISSUE;
      end
      SEQ_ISSUE: begin
        if (adv_i && tok_last) state_d = SEQ_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ch_i.ready = (state_q == SEQ_IDLE);
    issuing       = (state_q == SEQ_ISSUE);
  end

  assign accept = in_ch_i.valid && in_ch_i.ready;

  // clip the block to the rows left in the batch
  always_comb begin
    row_base = in_ch_i.start_batch ? '0 : row_q;
    limit    = (cfg_q < CFG_W'(MAX_ROWS)) ? ROW_W'(cfg_q) : ROW_W'(MAX_ROWS);
    room     = (row_base < limit) ? (limit - row_base) : '0;
    count    = (in_ch_i.selector == SEL_RUN) ?
               in_ch_i.block_word[WORD_W-1:RUN_VAL_W] :
               RUN_CNT_W'(FIELD_COUNT[in_ch_i.selector]);
    n_room   = (count < RUN_CNT_W'(room)) ? ROW_W'(count) : room;
    n_take   = (32'(n_room) > CAP_ROWS) ? ROW_W'(CAP_ROWS) : n_room;
  end

  assign tok_last = (rem_q <= ROW_W'(LANES));
  assign tok_cnt  = tok_last ? CNT_W'(rem_q) : CNT_W'(LANES);

  always_comb begin
    tok_o = '0;
    tok_o.vld = issuing;
    if (issuing) begin
      tok_o.clr       = clr_q;
      tok_o.last      = tok_last;
      tok_o.cnt       = tok_cnt;
      tok_o.first_row = FIRST_ROW_W'(row_q);
    end
  end

  assign sel_o  = sel_q;
  assign word_o = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      cfg_q   <= ROW_LIMIT_RESET;
      row_q   <= '0;
      rem_q   <= '0;
      clr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (accept) begin
        row_q <= row_base;
        rem_q <= n_take;
        clr_q <= in_ch_i.start_batch;
      end else if (issuing && adv_i) begin
        row_q <= row_q + ROW_W'(tok_cnt);
        rem_q <= rem_q - ROW_W'(tok_cnt);
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_ch_i.block_word;
      sel_q  <= in_ch_i.selector;
    end else if (issuing && adv_i) begin
      word_q <= word_q >> group_shift(sel_q);
    end
  end

`ifndef ASSERT_OFF
  a_rows_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing |-> ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(rem_q)) <= (ROW_W + 1)'(MAX_ROWS))
    else $error("group issue runs past the row range");
  a_full_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.vld && !tok_o.last) |-> (tok_o.cnt == CNT_W'(LANES)))
    else $error("non-final group is not full");
`endif
endmodule

/* src/s8dd_lane.sv */
// ----------------------------------------------------------------------------
// s8dd_lane
// One decode lane: picks its field out of the packed word and zigzag-decodes
// it into a delta-of-delta.
// ----------------------------------------------------------------------------
module s8dd_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [s8dd_pkg::SEL_W-1:0]    sel_i,
  input  logic [s8dd_pkg::WORD_W-1:0]   word_i,
  input  logic [s8dd_pkg::LANE_W-1:0]   lane_i,
  input  logic [s8dd_pkg::CNT_W-1:0]    cnt_i,
  output logic [s8dd_pkg::VW-1:0]       dd_o
);
  import s8dd_pkg::*;

  logic [SHIFT_W-1:0] shamt;
  logic [WORD_W-1:0]  field;
  logic [VW-1:0]      dd_d, dd_q;

  always_comb begin
    shamt = SHIFT_W'(FIELD_BITS[sel_i] * lane_i);
    if (sel_i == SEL_RUN) begin
      field = word_i & RUN_MASK;
    end else begin
      field = (word_i >> shamt) & field_mask(sel_i);
    end
    // idle lanes add nothing to the prefix sums
    dd_d = (CNT_W'(lane_i) < cnt_i) ? unzigzag(field) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dd_q <= dd_d;
  end

  assign dd_o = dd_q;
endmodule

/* src/s8dd_prefix.sv */
// ----------------------------------------------------------------------------
// s8dd_prefix
// Registered inclusive prefix sum across the lanes, one doubling step per
// stage, with the group tag carried alongside.
// ----------------------------------------------------------------------------
module s8dd_prefix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  s8dd_pkg::grp_meta_t       meta_i,
  input  logic [s8dd_pkg::VW-1:0]   x_i [s8dd_pkg::LANES],
  output s8dd_pkg::grp_meta_t       meta_o,
  output logic [s8dd_pkg::VW-1:0]   y_o [s8dd_pkg::LANES]
);
  import s8dd_pkg::*;

  logic [VW-1:0] lvl_q  [PFX_LEVELS][LANES];
  grp_meta_t     meta_q [PFX_LEVELS];

  for (genvar l = 0; l < PFX_LEVELS; l++) begin : g_lvl
    logic [VW-1:0] src [LANES];
    logic [VW-1:0] sum [LANES];
    grp_meta_t     msrc;

    if (l == 0) begin : g_first
      assign src  = x_i;
      assign msrc = meta_i;
    end else begin : g_next
      assign src  = lvl_q[l-1];
      assign msrc = meta_q[l-1];
    end

    for (genvar k = 0; k < LANES; k++) begin : g_k
      if (k >= (1 << l)) begin : g_add
        assign sum[k] = src[k] + src[k - (1 << l)];
      end else begin : g_keep
        assign sum[k] = src[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[l] <= '0;
      end else if (en_i) begin
        meta_q[l] <= msrc;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) lvl_q[l] <= sum;
    end
  end

  assign y_o    = lvl_q[PFX_LEVELS-1];
  assign meta_o = meta_q[PFX_LEVELS-1];
endmodule

/* src/s8dd_accum.sv */
// ----------------------------------------------------------------------------
// s8dd_accum
// Merge stage: adds the running delta and value to the lane prefix sums,
// updates the running state and holds the outgoing row group beat.
// ----------------------------------------------------------------------------
module s8dd_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  s8dd_pkg::grp_meta_t       meta_i,
  input  logic [s8dd_pkg::VW-1:0]   s_i [s8dd_pkg::LANES],
  s8dd_out_if.source                out_ch_o,
  output logic                      adv_o
);
  import s8dd_pkg::*;

  logic [VW-1:0]          d_q, v_q;
  logic [VW-1:0]          base_d, base_v, d_new, v_new;
  logic [VW-1:0]          lane_v [LANES];
  logic [OUT_W-1:0]       val_d [OUT_LANES];
  logic [OUT_W-1:0]       val_q [OUT_LANES];
  logic                   out_vld_q;
  logic [FIRST_ROW_W-1:0] first_row_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   done_q;

  assign adv_o = !out_vld_q || out_ch_o.ready;

  always_comb begin
    base_d = meta_i.clr ? '0 : d_q;
    base_v = meta_i.clr ? '0 : v_q;
    for (int k = 0; k < LANES; k++) begin
      lane_v[k] = base_v + VW'(base_d * VW'(k + 1)) + s_i[k];
    end
    for (int k = 0; k < OUT_LANES; k++) begin
      val_d[k] = '0;
      if ((k < LANES) && (CNT_W'(k) < meta_i.cnt)) begin
        val_d[k] = OUT_W'($signed(lane_v[LANE_W'(k)]));
      end
    end
    d_new = base_d + meta_i.total;
    v_new = (meta_i.cnt != '0) ? lane_v[LANE_W'(meta_i.cnt - 1'b1)] : base_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q       <= '0;
      v_q       <= '0;
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= meta_i.vld && (meta_i.cnt != '0);
      if (meta_i.vld) begin
        d_q <= d_new;
        v_q <= v_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      first_row_q <= meta_i.first_row;
      cnt_q       <= meta_i.cnt;
      done_q      <= meta_i.last;
      val_q       <= val_d;
    end
  end

  assign out_ch_o.valid      = out_vld_q;
  assign out_ch_o.first_row  = first_row_q;
  assign out_ch_o.lane_count = cnt_q;
  assign out_ch_o.value_0    = val_q[0];
  assign out_ch_o.value_1    = val_q[1];
  assign out_ch_o.value_2    = val_q[2];
  assign out_ch_o.value_3    = val_q[3];
  assign out_ch_o.value_4    = val_q[4];
  assign out_ch_o.value_5    = val_q[5];
  assign out_ch_o.value_6    = val_q[6];
  assign out_ch_o.value_7    = val_q[7];
  assign out_ch_o.block_done = done_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((cnt_q != '0) && (cnt_q <= CNT_W'(LANES))))
    else $error("row group beat with bad lane count");
  a_idle_lane_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (cnt_q < CNT_W'(OUT_LANES))) |-> (val_q[OUT_LANES-1] == '0))
    else $error("unused top lane carries data");
`endif
endmodule

/* src/simple8b_delta_delta_decoder_top.sv */
// ----------------------------------------------------------------------------
// simple8b_delta_delta_decoder_top
// A block beat passes the sequencer, lane, delta prefix, value prefix and
// merge registers. The sequencer issues one eight-lane group per cycle
// while the output is not stalled and takes no new block beat until its
// last group is issued. Reset clears running delta, value and row position
// and sets the row limit to 512.
// ----------------------------------------------------------------------------
module simple8b_delta_delta_decoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  s8dd_in_if.sink                     in_ch_i,
  s8dd_out_if.source                  out_ch_o,
  input  logic                        cfg_we_i,
  input  logic [s8dd_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import s8dd_pkg::*;

  logic              adv;
  grp_meta_t         tok;
  grp_meta_t         meta1_q;
  grp_meta_t         meta2, meta2x, meta3;
  logic [SEL_W-1:0]  sel;
  logic [WORD_W-1:0] word;
  logic [VW-1:0]     dd [LANES];
  logic [VW-1:0]     p  [LANES];
  logic [VW-1:0]     s  [LANES];

  s8dd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch_i     (in_ch_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .tok_o       (tok),
    .sel_o       (sel),
    .word_o      (word)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    s8dd_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .sel_i  (sel),
      .word_i (word),
      .lane_i (LANE_W'(k)),
      .cnt_i  (tok.cnt),
      .dd_o   (dd[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
    end else if (adv) begin
      meta1_q <= tok;
    end
  end

  // running delta prefix
  s8dd_prefix u_pfx_delta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .meta_i (meta1_q),
    .x_i    (dd),
    .meta_o (meta2),
    .y_o    (p)
  );

  always_comb begin
    meta2x       = meta2;
    meta2x.total = p[LANES-1];
  end

  // running value prefix
  s8dd_prefix u_pfx_value (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .meta_i (meta2x),
    .x_i    (p),
    .meta_o (meta3),
    .y_o    (s)
  );

  s8dd_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .meta_i   (meta3),
    .s_i      (s),
    .out_ch_o (out_ch_o),
    .adv_o    (adv)
  );
endmodule
